[design/vn3_pkg.sv]
// Package for the three-component vector normalizer.
// Holds widths, the per-stage carry type and shared constants; no dependencies.
package vn3_pkg;

   localparam int CompW  = 16;            // component width
   localparam int UnitW  = 16;            // Q1.15 result width
   localparam int LenW   = 16;            // width of the reported length
   localparam int FracW  = UnitW - 1;     // quotient bits below the binary point
   localparam int SqW    = 2 * CompW;     // one squared component
   localparam int RadW   = 2 * CompW + 2; // sum of three squares, rounded up to even
   localparam int RootW  = RadW / 2;      // floor root width
   localparam int SremW  = RootW + 3;     // root remainder after shifting in two bits
   localparam int DremW  = RootW + 1;     // divider partial remainder
   localparam int SqSteps = RootW;        // one root bit per stage

   localparam logic [UnitW-1:0] UnitMax = {1'b0, {(UnitW-1){1'b1}}};

   // Signs and magnitudes of the three components, carried down the pipe.
   typedef struct packed {
      logic [2:0]            neg;
      logic [2:0][CompW-1:0] mag;
   } vec_type;

endpackage

[design/vector3_normalize.sv]
// Top level of the three-component vector normalizer pipeline.
// Depends on vn3_pkg for widths, constants and the carry type.

// vector3_normalize takes one vector of three signed components per transaction
// and returns each component divided by the floor integer square root of the
// sum of squares, as a Q1.15 value truncated toward zero and saturated to
// +/-32767, together with that floor root and a flag for the all-zero vector
// (whose unit outputs and length are zero). The block is a fixed pipeline
// that accepts one transaction every cycle unless a result is stalled at the
// output. It has one stage for the absolute values, one for the squares, one
// for the sum, one stage per root bit of the digit-by-digit square root, one
// stage that sets up the dividers, one stage per quotient bit of three
// restoring dividers that run side by side, and the output register. The
// whole pipe holds when a finished result is stalled at the output, so
// req_stall follows rsp_stall while a result is waiting.
module vector3_normalize (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [vn3_pkg::CompW-1:0]    req_comp_x,
   input  logic [vn3_pkg::CompW-1:0]    req_comp_y,
   input  logic [vn3_pkg::CompW-1:0]    req_comp_z,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [vn3_pkg::UnitW-1:0]    rsp_unit_x,
   output logic [vn3_pkg::UnitW-1:0]    rsp_unit_y,
   output logic [vn3_pkg::UnitW-1:0]    rsp_unit_z,
   output logic [vn3_pkg::LenW-1:0]     rsp_length,
   output logic                         rsp_zero_vector
);
   import vn3_pkg::*;

   // The pipe advances whenever the output register is free or being taken.
   logic advance;
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // Stage A: absolute values and signs.
   logic    vld_a_ff;
   vec_type vec_a_ff, vec_a_in;
   logic [2:0][CompW-1:0] comp_raw;
   assign comp_raw = {req_comp_z, req_comp_y, req_comp_x};

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         vec_a_in.neg[c] = comp_raw[c][CompW-1];
         vec_a_in.mag[c] = comp_raw[c][CompW-1] ? (~comp_raw[c] + 1'b1) : comp_raw[c];
      end
   end

   // Stage B: one square per component.
   logic    vld_b_ff;
   vec_type vec_b_ff;
   logic [2:0][SqW-1:0] sqr_ff, sqr_in;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sqr_in[c] = SqW'(vec_a_ff.mag[c]) * SqW'(vec_a_ff.mag[c]);
      end
   end

   // Root stages: index 0 holds the sum, index k holds the state after k root bits.
   logic    [SqSteps:0]             sq_vld_ff;
   vec_type [SqSteps:0]             sq_vec_ff;
   logic    [SqSteps:0][RadW-1:0]   sq_rad_ff, sq_rad_in;
   logic    [SqSteps:0][SremW-1:0]  sq_rem_ff, sq_rem_in;
   logic    [SqSteps:0][RootW-1:0]  sq_root_ff, sq_root_in;

   always_comb begin
      logic [SremW-1:0] rem_sh;
      logic [SremW-1:0] trial;
      sq_rad_in[0]  = RadW'(sqr_ff[0]) + RadW'(sqr_ff[1]) + RadW'(sqr_ff[2]);
      sq_rem_in[0]  = '0;
      sq_root_in[0] = '0;
      for (int k = 0; k < SqSteps; k++) begin
         // Bring down the next two radicand bits and try a one in the root.
         rem_sh = {sq_rem_ff[k][SremW-3:0], sq_rad_ff[k][RadW-1:RadW-2]};
         trial  = SremW'({sq_root_ff[k], 2'b01});
         sq_rad_in[k+1] = {sq_rad_ff[k][RadW-3:0], 2'b00};
         if (rem_sh >= trial) begin
            sq_rem_in[k+1]  = rem_sh - trial;
            sq_root_in[k+1] = {sq_root_ff[k][RootW-2:0], 1'b1};
         end else begin
            sq_rem_in[k+1]  = rem_sh;
            sq_root_in[k+1] = {sq_root_ff[k][RootW-2:0], 1'b0};
         end
      end
   end

   // Divider stages: index 0 is set up from the root, index j holds j quotient bits.
   // A component not below the root saturates, so only FracW bits are needed.
   logic    [FracW:0]                   dv_vld_ff;
   vec_type [FracW:0]                   dv_vec_ff;
   logic    [FracW:0][RootW-1:0]        dv_len_ff, dv_len_in;
   logic    [FracW:0][2:0]              dv_sat_ff, dv_sat_in;
   logic    [FracW:0][2:0][DremW-1:0]   dv_rem_ff, dv_rem_in;
   logic    [FracW:0][2:0][FracW-1:0]   dv_q_ff, dv_q_in;

   always_comb begin
      logic [DremW-1:0] rem_sh;
      dv_len_in[0] = sq_root_ff[SqSteps];
      for (int c = 0; c < 3; c++) begin
         dv_sat_in[0][c] = RootW'(sq_vec_ff[SqSteps].mag[c]) >= sq_root_ff[SqSteps];
         dv_rem_in[0][c] = DremW'(sq_vec_ff[SqSteps].mag[c]);
         dv_q_in[0][c]   = '0;
      end
      for (int j = 0; j < FracW; j++) begin
         dv_len_in[j+1] = dv_len_ff[j];
         dv_sat_in[j+1] = dv_sat_ff[j];
         for (int c = 0; c < 3; c++) begin
            rem_sh = {dv_rem_ff[j][c][DremW-2:0], 1'b0};
            if (rem_sh >= DremW'(dv_len_ff[j])) begin
               dv_rem_in[j+1][c] = rem_sh - DremW'(dv_len_ff[j]);
               dv_q_in[j+1][c]   = {dv_q_ff[j][c][FracW-2:0], 1'b1};
            end else begin
               dv_rem_in[j+1][c] = rem_sh;
               dv_q_in[j+1][c]   = {dv_q_ff[j][c][FracW-2:0], 1'b0};
            end
         end
      end
   end

   // Output stage: saturate, restore the sign and handle the zero vector.
   logic                  rsp_valid_ff;
   logic [2:0][UnitW-1:0] unit_ff, unit_in;
   logic [LenW-1:0]       len_ff, len_in;
   logic                  zero_ff, zero_in;

   always_comb begin
      logic [UnitW-1:0] mag_q;
      zero_in = (dv_len_ff[FracW] == '0);
      len_in  = LenW'(dv_len_ff[FracW]);
      for (int c = 0; c < 3; c++) begin
         mag_q = dv_sat_ff[FracW][c] ? UnitMax : {1'b0, dv_q_ff[FracW][c]};
         if (zero_in) begin
            unit_in[c] = '0;
         end else if (dv_vec_ff[FracW].neg[c]) begin
            unit_in[c] = ~mag_q + 1'b1;
         end else begin
            unit_in[c] = mag_q;
         end
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff     <= 1'b0;
         vld_b_ff     <= 1'b0;
         sq_vld_ff    <= '0;
         dv_vld_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_a_ff     <= req_valid;
         vld_b_ff     <= vld_a_ff;
         sq_vld_ff    <= {sq_vld_ff[SqSteps-1:0], vld_b_ff};
         dv_vld_ff    <= {dv_vld_ff[FracW-1:0], sq_vld_ff[SqSteps]};
         rsp_valid_ff <= dv_vld_ff[FracW];
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (advance) begin
         vec_a_ff      <= vec_a_in;
         vec_b_ff      <= vec_a_ff;
         sqr_ff        <= sqr_in;
         sq_vec_ff[0]  <= vec_b_ff;
         for (int k = 0; k < SqSteps; k++) begin
            sq_vec_ff[k+1] <= sq_vec_ff[k];
         end
         sq_rad_ff     <= sq_rad_in;
         sq_rem_ff     <= sq_rem_in;
         sq_root_ff    <= sq_root_in;
         dv_vec_ff[0]  <= sq_vec_ff[SqSteps];
         for (int j = 0; j < FracW; j++) begin
            dv_vec_ff[j+1] <= dv_vec_ff[j];
         end
         dv_len_ff     <= dv_len_in;
         dv_sat_ff     <= dv_sat_in;
         dv_rem_ff     <= dv_rem_in;
         dv_q_ff       <= dv_q_in;
         unit_ff       <= unit_in;
         len_ff        <= len_in;
         zero_ff       <= zero_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_unit_x      = unit_ff[0];
   assign rsp_unit_y      = unit_ff[1];
   assign rsp_unit_z      = unit_ff[2];
   assign rsp_length      = len_ff;
   assign rsp_zero_vector = zero_ff;

`ifndef NO_ASSERTIONS
   // A zero vector reports a zero length and a zero x unit.
   a_zero_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_vector |-> rsp_length == '0 && rsp_unit_x == '0)
      else $error("zero vector with nonzero outputs");

   // Saturation keeps every unit component off the most negative code.
   a_no_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_unit_x != {1'b1, {(UnitW-1){1'b0}}}
                 && rsp_unit_y != {1'b1, {(UnitW-1){1'b0}}}
                 && rsp_unit_z != {1'b1, {(UnitW-1){1'b0}}})
      else $error("unit component reached the most negative code");

   // A result held at the output stays valid with a steady length and frozen divider valid bits.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_length)
                                 && $stable(dv_vld_ff))
      else $error("pipeline moved while output was stalled");
`endif

endmodule
